// File: sv/shh_pkg.sv
// Shared types, constants and helpers for the space-saving heavy hitters unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package shh_pkg;

    localparam logic [31:0] EMPTY_ITEM = 32'h7FFF_FFFF;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_SLOT   = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic ACTION_UPDATE = 1'b0;
    localparam logic ACTION_REPORT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] item_key;
        logic [31:0] weight;
        logic [31:0] threshold;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [31:0] out_item;
        logic [31:0] out_count;
        logic [31:0] error_bound;
        logic        last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic in_load;
        logic clr_wr;
        logic rd_idx;
        logic idx_inc;
        logic u_chk;
        logic hit_set;
        logic miss_set;
        logic sift_rd;
        logic sift_step;
        logic pend_take;
        logic emit_upd;
        logic emit_pend;
        logic pend_last;
        logic emit_none;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic in_report;
        logic idx_last;
        logic match;
        logic qualifies;
        logic pend_v;
        logic out_free;
        logic sift_stop;
    } sts_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/space_saving_heavy_hitters_unit.sv
// Top level of the space-saving heavy hitters unit.
// Depends on shh_pkg, shh_controller and shh_datapath.
//
//   channel   valid       stall       beat
//   request   req_valid   req_stall   req (shh_pkg::req_t)
//   result    rsp_valid   rsp_stall   rsp (shh_pkg::rsp_t)
//
// After reset the slot memory is cleared, one slot per cycle, slots 1 to SLOTS;
// no request beat is taken during that pass.
// An update whose item sits in slot k scans slots 1 to k, then moves the slot down
// h heap levels and waits to emit while the result side stalls; a miss scans all
// SLOTS slots and sifts from the root.
// The match scan and the sift share one slot memory with two read ports and one
// write port, so each slot visited takes a read state and a check state.
// A report checks every slot, ends with a last beat and waits while the result stalls.
// One request is in work at a time; the result register lets the next request
// be taken while the previous result beat still waits for the consumer.
`default_nettype none

module space_saving_heavy_hitters_unit #(
    parameter int SLOTS = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire shh_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output shh_pkg::rsp_t      rsp
);

    shh_pkg::cmd_t cmd;
    shh_pkg::sts_t sts;

    // The controller holds only the state register; all slot storage lives in the datapath.
    shh_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    shh_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_valid (req_valid),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // A request beat is taken only while the controller waits for work.
    assign req_stall = !cmd.ready;

endmodule

`default_nettype wire

// File: sv/shh_datapath.sv
// Datapath: slot memory, scan index, sift registers and the result register.
// Depends on shh_pkg; driven by shh_controller through cmd_t and sts_t.
`default_nettype none

module shh_datapath #(
    parameter int SLOTS = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire shh_pkg::cmd_t cmd,
    output shh_pkg::sts_t     sts,
    input  wire logic         req_valid,
    input  wire shh_pkg::req_t req,
    input  wire logic         rsp_stall,
    output logic              rsp_valid,
    output shh_pkg::rsp_t     rsp
);

    localparam int AW    = $clog2(SLOTS + 1);
    localparam int CW    = AW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [AW-1:0] ONE_A  = AW'(1);
    localparam logic [AW-1:0] LAST_A = AW'(SLOTS);
    localparam logic [CW-1:0] LAST_C = CW'(SLOTS);

    logic [31:0] item_mem  [DEPTH];
    logic [31:0] count_mem [DEPTH];

    logic [31:0] rd0_item_reg, rd0_count_reg, rd1_item_reg, rd1_count_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] p_reg;
    logic [31:0] key_reg, weight_reg, thr_reg;
    logic [31:0] v_item_reg, v_count_reg, root_reg, err_reg;
    logic        hit_reg;
    logic        pend_v_reg;
    logic [31:0] pend_item_reg, pend_count_reg;
    logic        out_valid_reg, out_valid_next;
    shh_pkg::rsp_t out_reg, out_next;

    logic [CW-1:0] l_c, r_c;
    logic          l_ok, r_ok, mc_right, stop, out_free, rd_en, wr_en, load;
    logic [31:0]   child_item, child_count, wr_item, wr_count;
    logic [AW-1:0] mc_addr, ra0, ra1, wr_addr;

    // Children of the current hole position.
    assign l_c  = {p_reg, 1'b0};
    assign r_c  = {p_reg, 1'b1};
    assign l_ok = (l_c <= LAST_C);
    assign r_ok = (r_c <= LAST_C);

    assign mc_right    = r_ok && !(rd0_count_reg < rd1_count_reg);
    assign child_item  = mc_right ? rd1_item_reg  : rd0_item_reg;
    assign child_count = mc_right ? rd1_count_reg : rd0_count_reg;
    assign mc_addr     = mc_right ? r_c[AW-1:0] : l_c[AW-1:0];
    assign stop        = !l_ok || (v_count_reg < child_count);

    assign rd_en = cmd.rd_idx | cmd.sift_rd;
    assign ra0   = cmd.sift_rd ? l_c[AW-1:0] : idx_reg;
    assign ra1   = (cmd.sift_rd && r_ok) ? r_c[AW-1:0] : '0;

    assign wr_en    = cmd.clr_wr | cmd.sift_step;
    assign wr_addr  = cmd.clr_wr ? idx_reg : p_reg;
    assign wr_item  = cmd.clr_wr ? shh_pkg::EMPTY_ITEM : (stop ? v_item_reg : child_item);
    assign wr_count = cmd.clr_wr ? 32'd0 : (stop ? v_count_reg : child_count);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            item_mem[wr_addr]  <= wr_item;
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_en)
        begin
            rd0_item_reg  <= item_mem[ra0];
            rd0_count_reg <= count_mem[ra0];
            rd1_item_reg  <= item_mem[ra1];
            rd1_count_reg <= count_mem[ra1];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.in_load)
        begin
            idx_next = ONE_A;
        end
        else if (cmd.clr_wr || cmd.idx_inc)
        begin
            idx_next = idx_reg + ONE_A;
        end
    end

    assign out_free = !out_valid_reg || !rsp_stall;
    assign load     = cmd.emit_upd | cmd.emit_pend | cmd.emit_none;

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit_upd)
        begin
            out_next = '{kind: shh_pkg::KIND_UPDATE, hit: hit_reg, out_item: v_item_reg,
                         out_count: v_count_reg, error_bound: err_reg, last: 1'b1};
        end
        else if (cmd.emit_pend)
        begin
            out_next = '{kind: shh_pkg::KIND_SLOT, hit: 1'b0, out_item: pend_item_reg,
                         out_count: pend_count_reg, error_bound: err_reg,
                         last: cmd.pend_last};
        end
        else if (cmd.emit_none)
        begin
            out_next = '{kind: shh_pkg::KIND_NONE, hit: 1'b0, out_item: 32'd0,
                         out_count: 32'd0, error_bound: err_reg, last: 1'b1};
        end
        out_valid_next = load ? 1'b1 : (rsp_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= ONE_A;
            err_reg       <= 32'd0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.miss_set)
            begin
                err_reg <= root_reg;
            end
            if (cmd.in_load)
            begin
                pend_v_reg <= 1'b0;
            end
            else if (cmd.pend_take)
            begin
                pend_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.in_load)
        begin
            key_reg    <= req.item_key;
            weight_reg <= req.weight;
            thr_reg    <= req.threshold;
        end
        if (cmd.u_chk && idx_reg == ONE_A)
        begin
            root_reg <= rd0_count_reg;
        end
        if (cmd.hit_set)
        begin
            p_reg       <= idx_reg;
            v_item_reg  <= key_reg;
            v_count_reg <= shh_pkg::sat_add(rd0_count_reg, weight_reg);
            hit_reg     <= 1'b1;
        end
        else if (cmd.miss_set)
        begin
            p_reg       <= ONE_A;
            v_item_reg  <= key_reg;
            v_count_reg <= shh_pkg::sat_add(weight_reg, root_reg);
            hit_reg     <= 1'b0;
        end
        else if (cmd.sift_step && !stop)
        begin
            p_reg <= mc_addr;
        end
        if (cmd.pend_take)
        begin
            pend_item_reg  <= rd0_item_reg;
            pend_count_reg <= rd0_count_reg;
        end
    end

    assign sts.in_valid  = req_valid;
    assign sts.in_report = (req.action == shh_pkg::ACTION_REPORT);
    assign sts.idx_last  = (idx_reg == LAST_A);
    assign sts.match     = (key_reg != shh_pkg::EMPTY_ITEM) && (rd0_item_reg == key_reg);
    assign sts.qualifies = (rd0_count_reg >= thr_reg);
    assign sts.pend_v    = pend_v_reg;
    assign sts.out_free  = out_free;
    assign sts.sift_stop = stop;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// File: sv/shh_controller.sv
// Controller state machine: clearing pass, match scan, sift and report scan.
// Depends on shh_pkg; talks to shh_datapath through cmd_t and sts_t only.
`default_nettype none

module shh_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire shh_pkg::sts_t sts,
    output shh_pkg::cmd_t      cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_UREAD = 10'b00_0000_0100,
        ST_UCHK  = 10'b00_0000_1000,
        ST_SREAD = 10'b00_0001_0000,
        ST_SCMP  = 10'b00_0010_0000,
        ST_EMIT  = 10'b00_0100_0000,
        ST_RREAD = 10'b00_1000_0000,
        ST_RCHK  = 10'b01_0000_0000,
        ST_RFIN  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = sts.in_report ? ST_RREAD : ST_UREAD;
                end
            end
            ST_UREAD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_UCHK;
            end
            ST_UCHK:
            begin
                cmd.u_chk = 1'b1;
                if (sts.match)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = ST_SREAD;
                end
                else if (sts.idx_last)
                begin
                    cmd.miss_set = 1'b1;
                    state_next   = ST_SREAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_UREAD;
                end
            end
            ST_SREAD:
            begin
                cmd.sift_rd = 1'b1;
                state_next  = ST_SCMP;
            end
            ST_SCMP:
            begin
                cmd.sift_step = 1'b1;
                state_next    = sts.sift_stop ? ST_EMIT : ST_SREAD;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_upd = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RREAD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                if (!(sts.qualifies && sts.pend_v && !sts.out_free))
                begin
                    if (sts.qualifies)
                    begin
                        cmd.emit_pend = sts.pend_v;
                        cmd.pend_take = 1'b1;
                    end
                    if (sts.idx_last)
                    begin
                        state_next = ST_RFIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RREAD;
                    end
                end
            end
            ST_RFIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_pend = sts.pend_v;
                    cmd.pend_last = 1'b1;
                    cmd.emit_none = !sts.pend_v;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/shh_checker.sv
// Port-level checker for the space-saving heavy hitters unit, with its bind.
// Depends on shh_pkg; sees only the ports of space_saving_heavy_hitters_unit.
`default_nettype none

module shh_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire shh_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire shh_pkg::rsp_t rsp
);

    // A stalled result beat stays and holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Every update result closes its request.
    a_upd_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == shh_pkg::KIND_UPDATE |-> rsp.last)
        else $error("update result without last");

    // An empty report is a single closing beat with no hit flag and a zero count.
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == shh_pkg::KIND_NONE |->
            rsp.last && !rsp.hit && rsp.out_count == 32'd0)
        else $error("malformed empty report");

    // Report beats never carry the hit flag.
    a_slot_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == shh_pkg::KIND_SLOT |-> !rsp.hit)
        else $error("report beat with hit set");

endmodule

bind space_saving_heavy_hitters_unit shh_checker u_shh_checker (.*);

`default_nettype wire
